>>> hw/rtl/dqfa_pkg.sv
// dqfa_pkg: shared types, constants and phase codes for the dns answer block
// no dependencies

package dqfa_pkg;

    // sizing of query and response
    localparam int RESPONSE_BYTES  = 128;
    localparam int MAX_QUERY_BYTES = 512;
    localparam int ANSWER_BYTES    = 16;
    localparam int HEADER_BYTES    = 12;
    localparam int TAIL_BYTES      = 4;

    localparam int POS_W  = $clog2(MAX_QUERY_BYTES + 1);
    localparam int CNT_W  = $clog2(RESPONSE_BYTES + 1);
    localparam int ANS_W  = $clog2(ANSWER_BYTES);
    localparam int TAIL_W = $clog2(TAIL_BYTES + 1);

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_NAMELEN = 3'd1;
    localparam logic [2:0] PH_LABEL   = 3'd2;
    localparam logic [2:0] PH_TAIL    = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // fixed header and answer bytes
    localparam logic [7:0] FLAGS_HI     = 8'h81;
    localparam logic [7:0] FLAGS_LO     = 8'h80;
    localparam logic [7:0] COUNT_ONE    = 8'h01;
    localparam logic [7:0] NAME_PTR_HI  = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO  = 8'h0C;
    localparam logic [7:0] TYPE_CLASS   = 8'h01;
    localparam logic [7:0] RDLENGTH_LO  = 8'h04;
    localparam logic [7:0] QR_MASK      = 8'h80;

    // configuration register indexes
    localparam logic CFG_ANSWER_IP = 1'b0;
    localparam logic CFG_TTL       = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       abort;
    } resp_t;

endpackage

>>> hw/rtl/dqfa_parser.sv
// dqfa_parser: per-byte query parser, header rewrite and question echo
// depends on dqfa_pkg

module dqfa_parser
    import dqfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] query_byte,
    input  logic       end_of_packet,
    output logic       res_valid,
    output resp_t      res,
    output logic       start_burst
);

    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        label_reg, label_next;
    logic [TAIL_W-1:0] tail_reg,  tail_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;

    logic [7:0]        hdr_val;
    logic              ab;
    logic              complete;
    logic              too_long;
    logic              too_big;

    always_comb
    begin
        case (pos_reg) inside
            POS_W'(0), POS_W'(1): hdr_val = query_byte;
            POS_W'(2):            hdr_val = FLAGS_HI;
            POS_W'(3):            hdr_val = FLAGS_LO;
            POS_W'(5), POS_W'(7): hdr_val = COUNT_ONE;
            default:              hdr_val = 8'h00;
        endcase
    end

    assign too_long = (pos_reg >= POS_W'(MAX_QUERY_BYTES));
    assign too_big  = (({1'b0, cnt_reg} + (CNT_W+1)'(ANSWER_BYTES + 1))
                       > (CNT_W+1)'(RESPONSE_BYTES));

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        label_next  = label_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        res_valid   = 1'b0;
        res         = '{data: query_byte, last: 1'b0, abort: 1'b0};
        start_burst = 1'b0;
        ab          = 1'b0;
        complete    = 1'b0;
        if (take)
        begin
            if (!too_long)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            unique case (phase_reg) inside
                PH_HEADER:
                begin
                    if (((pos_reg == POS_W'(2)) && ((query_byte & QR_MASK) != 8'h00))
                        || end_of_packet)
                    begin
                        ab = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.data  = hdr_val;
                        cnt_next  = cnt_reg + CNT_W'(1);
                        if (pos_reg >= POS_W'(HEADER_BYTES - 1))
                        begin
                            phase_next = PH_NAMELEN;
                        end
                    end
                end
                PH_NAMELEN, PH_LABEL, PH_TAIL:
                begin
                    if (too_long || too_big)
                    begin
                        ab = 1'b1;
                    end
                    else
                    begin
                        unique case (phase_reg) inside
                            PH_NAMELEN:
                            begin
                                if (query_byte == 8'h00)
                                begin
                                    phase_next = PH_TAIL;
                                    tail_next  = '0;
                                end
                                else
                                begin
                                    label_next = query_byte;
                                    phase_next = PH_LABEL;
                                end
                            end
                            PH_LABEL:
                            begin
                                label_next = (label_reg != 8'h00) ? label_reg - 8'd1 : 8'h00;
                                if (label_next == 8'h00)
                                begin
                                    phase_next = PH_NAMELEN;
                                end
                            end
                            default:
                            begin
                                tail_next = tail_reg + TAIL_W'(1);
                                if (tail_next >= TAIL_W'(TAIL_BYTES))
                                begin
                                    complete   = 1'b1;
                                    phase_next = PH_DONE;
                                end
                            end
                        endcase
                        if (end_of_packet && !complete)
                        begin
                            ab = 1'b1;
                        end
                        else
                        begin
                            res_valid   = 1'b1;
                            start_burst = complete;
                            cnt_next    = cnt_reg + CNT_W'(1)
                                          + (complete ? CNT_W'(ANSWER_BYTES) : CNT_W'(0));
                        end
                    end
                end
                default:
                begin
                    // done, discard and unused codes: nothing out
                end
            endcase
            if (ab)
            begin
                res_valid  = 1'b1;
                res        = '{data: 8'h00, last: 1'b1, abort: 1'b1};
                phase_next = PH_DISCARD;
            end
            if (end_of_packet)
            begin
                pos_next   = '0;
                phase_next = PH_HEADER;
                label_next = 8'h00;
                tail_next  = '0;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            label_reg <= 8'h00;
            tail_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            label_reg <= label_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/dqfa_answer.sv
// dqfa_answer: sequencer for the 16-byte a-record answer
// depends on dqfa_pkg

module dqfa_answer
    import dqfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        advance,
    input  logic [31:0] answer_ip,
    input  logic [31:0] ttl_seconds,
    output logic        busy,
    output resp_t       res
);

    logic             busy_reg, busy_next;
    logic [ANS_W-1:0] idx_reg,  idx_next;
    logic [7:0]       val;

    always_comb
    begin
        case (idx_reg)
            ANS_W'(0):  val = NAME_PTR_HI;
            ANS_W'(1):  val = NAME_PTR_LO;
            ANS_W'(3):  val = TYPE_CLASS;
            ANS_W'(5):  val = TYPE_CLASS;
            ANS_W'(6):  val = ttl_seconds[31:24];
            ANS_W'(7):  val = ttl_seconds[23:16];
            ANS_W'(8):  val = ttl_seconds[15:8];
            ANS_W'(9):  val = ttl_seconds[7:0];
            ANS_W'(11): val = RDLENGTH_LO;
            ANS_W'(12): val = answer_ip[31:24];
            ANS_W'(13): val = answer_ip[23:16];
            ANS_W'(14): val = answer_ip[15:8];
            ANS_W'(15): val = answer_ip[7:0];
            default:    val = 8'h00;
        endcase
    end

    assign busy = busy_reg;
    assign res  = '{data: val, last: (idx_reg == ANS_W'(ANSWER_BYTES - 1)), abort: 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && advance)
        begin
            idx_next = idx_reg + ANS_W'(1);
            if (idx_reg == ANS_W'(ANSWER_BYTES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

>>> hw/rtl/dqfa_out_fifo.sv
// dqfa_out_fifo: two-entry result queue that drives the output channel
// depends on dqfa_pkg

module dqfa_out_fifo
    import dqfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  resp_t push_data,
    output logic  full,
    output logic  out_valid,
    input  logic  out_stall,
    output resp_t out_data
);

    resp_t       mem_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_reg, rd_reg;
    logic        do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/dns_query_to_fixed_answer.sv
// dns_query_to_fixed_answer: streaming dns responder, one fixed a record per query
// depends on dqfa_pkg, dqfa_parser, dqfa_answer, dqfa_out_fifo
// result bytes pass through the registered output queue after their query byte transfer
// throughput: one query byte per cycle while the queue has room; the byte that completes
// the question holds the input while the answer burst drains
// reset: rst_n async active low clears parser, burst and queue; registers go to defaults

module dns_query_to_fixed_answer
    import dqfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // query byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  query_byte,
    input  logic        end_of_packet,
    // response byte channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  resp_byte,
    output logic        resp_last,
    output logic        abort,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] answer_ip_reg;
    logic [31:0] ttl_reg;

    logic        accept;
    logic        p_valid;
    resp_t       p_res;
    logic        p_start;
    logic        burst_busy;
    resp_t       burst_res;
    logic        fifo_full;
    logic        push;
    resp_t       push_data;
    resp_t       out_data;

    // config writes are always accepted: cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_ip_reg <= 32'hC0A8_0401;
            ttl_reg       <= 32'd60;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ANSWER_IP: answer_ip_reg <= cfg_data;
                CFG_TTL:       ttl_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input waits while the answer burst runs or the queue is full;
    // both are registered, so no path from out_stall to in_stall
    assign in_stall = burst_busy || fifo_full;
    assign accept   = in_valid && !in_stall;

    dqfa_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (accept),
        .query_byte    (query_byte),
        .end_of_packet (end_of_packet),
        .res_valid     (p_valid),
        .res           (p_res),
        .start_burst   (p_start)
    );

    // burst steps forward whenever the queue has a free slot
    dqfa_answer u_answer (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (p_start),
        .advance     (!fifo_full),
        .answer_ip   (answer_ip_reg),
        .ttl_seconds (ttl_reg),
        .busy        (burst_busy),
        .res         (burst_res)
    );

    // parser and burst never push in the same cycle: input is held during a burst
    assign push      = (accept && p_valid) || (burst_busy && !fifo_full);
    assign push_data = burst_busy ? burst_res : p_res;

    dqfa_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign resp_byte = out_data.data;
    assign resp_last = out_data.last;
    assign abort     = out_data.abort;

endmodule

>>> hw/rtl/dqfa_checker.sv
// dqfa_checker: port-level assertions for dns_query_to_fixed_answer, bound to the top
// depends on dqfa_pkg only through the bound top level

module dqfa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] resp_byte,
    input logic       resp_last,
    input logic       abort
);

    // nothing leaves while reset is held
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // an abort result always closes the response
    a_abort_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && abort) |-> resp_last)
        else $error("abort without last");

    // an abort result carries a zero byte
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && abort) |-> (resp_byte == 8'h00))
        else $error("abort with nonzero byte");

    // a stalled transfer keeps its byte
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(resp_byte)))
        else $error("stalled result changed");

endmodule

bind dns_query_to_fixed_answer dqfa_checker u_dqfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .resp_byte (resp_byte),
    .resp_last (resp_last),
    .abort     (abort)
);

>>> verif/dns_query_to_fixed_answer_tb.sv
// dns_query_to_fixed_answer_tb: self-checking bench for the streaming dns answer block
// holds a byte-level predictor and scoreboard class; needs dqfa_pkg and the block's rtl only

module dns_query_to_fixed_answer_tb;
    import dqfa_pkg::*;

    // no-transfer cycles before the watchdog gives up
    localparam int STUCK_LIMIT = 2000;
    // settle time after the last expected byte
    localparam int DRAIN_CYCLES = 4;
    // long receiver hold-off, long enough to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 120;
    // hold-off starts once this many response bytes have gone through
    localparam int HOLD_OFF_AT = 150;
    // least number of random query bytes per configuration setting; queries are sent whole
    localparam int BYTES_PER_SETTING = 80;
    localparam int IDLE_PERCENT = 28;

    typedef enum {Q_GOOD, Q_CUT, Q_QR, Q_NOISE, Q_OVERSIZE} query_kind_t;

    // ------------------------------------------------------------------
    // scoreboard: tracks the parse state of the current query, builds the
    // expected response bytes and checks what comes out of the block
    // ------------------------------------------------------------------
    class answer_scoreboard;
        logic [31:0]       answer_ip;
        logic [31:0]       ttl_seconds;
        logic [POS_W-1:0]  query_pos;
        logic [2:0]        parse_phase;
        logic [7:0]        label_left;
        logic [TAIL_W-1:0] tail_seen;
        logic [CNT_W-1:0]  resp_count;
        resp_t             resp_due[$];
        int                errors;
        int                received;

        function new();
            answer_ip   = 32'hC0A8_0401;
            ttl_seconds = 32'd60;
            errors      = 0;
            received    = 0;
            clear_query();
        endfunction

        function void clear_query();
            query_pos   = '0;
            parse_phase = PH_HEADER;
            label_left  = '0;
            tail_seen   = '0;
            resp_count  = '0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == CFG_ANSWER_IP)
                answer_ip = value;
            else
                ttl_seconds = value;
        endfunction

        function void add_resp(logic [7:0] data, logic last, logic ab);
            resp_t r;
            r.data  = data;
            r.last  = last;
            r.abort = ab;
            resp_due.push_back(r);
        endfunction

        // one accepted query byte in, zero to seventeen response bytes due
        function void note_query_byte(logic [7:0] b, logic eop);
            logic [POS_W-1:0] pos;
            logic [7:0]       v;
            logic             bad;
            logic             complete;
            pos      = query_pos;
            bad      = 1'b0;
            complete = 1'b0;
            if (query_pos < MAX_QUERY_BYTES)
                query_pos++;
            case (parse_phase) inside
                PH_HEADER:
                begin
                    case (pos) inside
                        0, 1:    v = b;
                        2:       v = FLAGS_HI;
                        3:       v = FLAGS_LO;
                        5, 7:    v = COUNT_ONE;
                        default: v = 8'h00;
                    endcase
                    if ((pos == 2 && (b & QR_MASK) != 0) || eop)
                        bad = 1'b1;
                    else
                    begin
                        add_resp(v, 1'b0, 1'b0);
                        resp_count++;
                        if (pos >= HEADER_BYTES - 1)
                            parse_phase = PH_NAMELEN;
                    end
                end
                PH_NAMELEN, PH_LABEL, PH_TAIL:
                begin
                    if (pos >= MAX_QUERY_BYTES
                        || int'(resp_count) + 1 + ANSWER_BYTES > RESPONSE_BYTES)
                        bad = 1'b1;
                    else
                    begin
                        if (parse_phase == PH_NAMELEN)
                        begin
                            if (b == 8'h00)
                            begin
                                parse_phase = PH_TAIL;
                                tail_seen   = '0;
                            end
                            else
                            begin
                                label_left  = b;
                                parse_phase = PH_LABEL;
                            end
                        end
                        else if (parse_phase == PH_LABEL)
                        begin
                            if (label_left > 0)
                                label_left--;
                            if (label_left == 0)
                                parse_phase = PH_NAMELEN;
                        end
                        else
                        begin
                            tail_seen++;
                            if (tail_seen >= TAIL_BYTES)
                            begin
                                complete    = 1'b1;
                                parse_phase = PH_DONE;
                            end
                        end
                        if (eop && !complete)
                            bad = 1'b1;
                        else
                        begin
                            add_resp(b, 1'b0, 1'b0);
                            resp_count++;
                            if (complete)
                            begin
                                add_resp(NAME_PTR_HI, 1'b0, 1'b0);
                                add_resp(NAME_PTR_LO, 1'b0, 1'b0);
                                add_resp(8'h00, 1'b0, 1'b0);
                                add_resp(TYPE_CLASS, 1'b0, 1'b0);
                                add_resp(8'h00, 1'b0, 1'b0);
                                add_resp(TYPE_CLASS, 1'b0, 1'b0);
                                for (int i = 3; i >= 0; i--)
                                    add_resp(ttl_seconds[8*i +: 8], 1'b0, 1'b0);
                                add_resp(8'h00, 1'b0, 1'b0);
                                add_resp(RDLENGTH_LO, 1'b0, 1'b0);
                                for (int i = 3; i >= 0; i--)
                                    add_resp(answer_ip[8*i +: 8], i == 0, 1'b0);
                                resp_count += CNT_W'(ANSWER_BYTES);
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (bad)
            begin
                add_resp(8'h00, 1'b1, 1'b1);
                parse_phase = PH_DISCARD;
            end
            if (eop)
                clear_query();
        endfunction

        function void check_resp_byte(logic [7:0] data, logic last, logic ab);
            resp_t want;
            received++;
            if (resp_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected response byte %02h last %b abort %b",
                             data, last, ab);
                return;
            end
            want = resp_due.pop_front();
            if (want.data !== data || want.last !== last || want.abort !== ab)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at response %0d: expected %02h/%b/%b got %02h/%b/%b",
                             received, want.data, want.last, want.abort, data, last, ab);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  query_byte;
    logic        end_of_packet;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic        abort;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    answer_scoreboard sb;

    // {end_of_packet, byte} of the query being built
    logic [8:0] query_bytes[$];
    // both sides stop idling while this is set
    bit steady;
    int bytes_sent;

    dns_query_to_fixed_answer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .query_byte    (query_byte),
        .end_of_packet (end_of_packet),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .resp_byte     (resp_byte),
        .resp_last     (resp_last),
        .abort         (abort),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // query side
    // ------------------------------------------------------------------

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        query_byte    <= b;
        end_of_packet <= eop;
        // payload holds while the block stalls
        do
            @(posedge clk);
        while (in_stall);
        sb.note_query_byte(b, eop);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_query();
        foreach (query_bytes[i])
            send_byte(query_bytes[i][7:0], query_bytes[i][8]);
    endtask

    // random query of the given kind; well-formed queries get random names,
    // sometimes trailing junk after the question
    function automatic void build_query(query_kind_t kind);
        int n_labels;
        int len;
        int cut;
        query_bytes.delete();
        if (kind == Q_NOISE)
        begin
            len = $urandom_range(1, 20);
            repeat (len) query_bytes.push_back({1'b0, 8'($urandom)});
        end
        else
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                if (i == 2)
                    len = (kind == Q_QR) ? $urandom_range(128, 255) : $urandom_range(0, 127);
                else
                    len = $urandom_range(0, 255);
                query_bytes.push_back({1'b0, 8'(len)});
            end
            if (kind == Q_OVERSIZE)
            begin
                // one huge label: the echo runs out of room before it ends
                query_bytes.push_back({1'b0, 8'($urandom_range(100, 255))});
                repeat (104) query_bytes.push_back({1'b0, 8'($urandom)});
            end
            else
            begin
                n_labels = $urandom_range(0, 3);
                repeat (n_labels)
                begin
                    len = $urandom_range(1, 12);
                    query_bytes.push_back({1'b0, 8'(len)});
                    repeat (len) query_bytes.push_back({1'b0, 8'($urandom)});
                end
                query_bytes.push_back(9'h000);
                repeat (TAIL_BYTES) query_bytes.push_back({1'b0, 8'($urandom)});
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(1, 4)) query_bytes.push_back({1'b0, 8'($urandom)});
                if (kind == Q_CUT)
                begin
                    cut = $urandom_range(0, query_bytes.size() - 1);
                    while (query_bytes.size() > cut + 1)
                        void'(query_bytes.pop_back());
                end
            end
        end
        query_bytes[query_bytes.size() - 1][8] = 1'b1;
    endfunction

    function automatic query_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return Q_GOOD;
        else if (r < 72)
            return Q_CUT;
        else if (r < 82)
            return Q_QR;
        else if (r < 95)
            return Q_NOISE;
        else
            return Q_OVERSIZE;
    endfunction

    // stop offering bytes and wait until every expected response byte is out,
    // then give trailing no-result bytes time to clear the block
    task automatic drain_block();
        in_valid <= 1'b0;
        while (sb.resp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // writes both registers back to back, valid dropped once at the end
    task automatic set_answer(input logic [31:0] ip, input logic [31:0] ttl);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ANSWER_IP;
        cfg_data  <= ip;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_ANSWER_IP, ip);
        @(negedge clk);
        cfg_index <= CFG_TTL;
        cfg_data  <= ttl;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_TTL, ttl);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // response side: random stall, plus one long hold-off while the
    // query side keeps offering bytes
    // ------------------------------------------------------------------
    initial
    begin : resp_stall_gen
        bit held_once;
        held_once = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_once && sb.received >= HOLD_OFF_AT)
            begin
                held_once = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // every response transfer is checked against the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_resp_byte(resp_byte, resp_last, abort);
    end

    // watchdog: any transfer on any channel resets the count
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        wait (rst_n === 1'b1);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        sb            = new();
        steady        = 1'b0;
        bytes_sent    = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        query_byte    = 8'h00;
        end_of_packet = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ANSWER_IP;
        cfg_data      = 32'h0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed, with the reset answer settings
        // short packet: ends on the first header byte
        send_byte(8'hFF, 1'b1);
        // response bit set in the flags
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        // smallest complete query: root name, then type and class
        query_bytes.delete();
        query_bytes.push_back(9'h0FF);
        query_bytes.push_back(9'h000);
        query_bytes.push_back(9'h001);
        repeat (HEADER_BYTES - 3) query_bytes.push_back(9'h000);
        query_bytes.push_back(9'h000);
        query_bytes.push_back(9'h000);
        query_bytes.push_back(9'h001);
        query_bytes.push_back(9'h000);
        query_bytes.push_back(9'h101);
        send_query();

        // random queries under three answer settings: all zero, all ones, random
        for (int setting = 0; setting < 3; setting++)
        begin
            int n_queries;
            drain_block();
            case (setting)
                0:       set_answer(32'h0000_0000, 32'h0000_0000);
                1:       set_answer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_answer($urandom, $urandom);
            endcase
            bytes_sent = 0;
            n_queries  = 0;
            while (bytes_sent < BYTES_PER_SETTING)
            begin
                // stretch with no idling on either side
                steady = (setting == 1 && n_queries < 4);
                if (setting == 0 && n_queries == 0)
                    build_query(Q_CUT);
                else if (setting == 0 && n_queries == 1)
                    build_query(Q_OVERSIZE);
                else
                    build_query(pick_kind());
                send_query();
                n_queries++;
            end
            steady = 1'b0;
        end

        drain_block();
        if (sb.errors == 0 && sb.resp_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
